### sv/ccal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccal_pkg;

   localparam int YEAR_FIELD_BITS = 16;
   localparam int YEAR_MAX_BITS   = 32;
   localparam int YEAR_BITS_DFLT  = 16;

   localparam logic [5:0]  LAST_SECOND = 6'd59;
   localparam logic [5:0]  LAST_MINUTE = 6'd59;
   localparam logic [4:0]  LAST_HOUR   = 5'd23;
   localparam logic [3:0]  MONTH_JAN   = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_APR   = 4'd4;
   localparam logic [3:0]  MONTH_JUN   = 4'd6;
   localparam logic [3:0]  MONTH_SEP   = 4'd9;
   localparam logic [3:0]  MONTH_NOV   = 4'd11;
   localparam logic [3:0]  MONTH_DEC   = 4'd12;
   localparam logic [4:0]  FIRST_DAY   = 5'd1;
   localparam logic [11:0] MOD25_BIAS  = 12'd1050;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                     command;
      logic [4:0]                  load_hour;
      logic [5:0]                  load_minute;
      logic [5:0]                  load_second;
      logic [4:0]                  load_day;
      logic [3:0]                  load_month;
      logic [YEAR_FIELD_BITS-1:0]  load_year;
   } req_type;

   typedef struct packed {
      logic [4:0]                  hour;
      logic [5:0]                  minute;
      logic [5:0]                  second;
      logic [4:0]                  day;
      logic [3:0]                  month;
      logic [YEAR_FIELD_BITS-1:0]  year;
      logic                        midnight_rollover;
      logic                        load_rejected;
   } rsp_type;

   // Since 1024 is -1 modulo 25, the year folds into an alternating sum of
   // 10-bit chunks before a small reciprocal step finds the residue.
   function automatic logic is_leap(input logic [YEAR_MAX_BITS-1:0] y);
      logic [11:0] s;
      logic [16:0] prod;
      logic [6:0]  q;
      logic [12:0] r;
      logic [4:0]  m25;
      logic        div25;
      s = MOD25_BIAS + 12'(y[9:0]) + 12'(y[29:20]) - 12'(y[19:10]) - 12'(y[31:30]);
      prod = 17'(s) * 17'd41;
      q = prod[16:10];
      r = 13'(s) - 13'(q) * 13'd25;
      m25 = r[12] ? 5'(r + 13'd25) : 5'(r);
      div25 = (m25 == 5'd0);
      return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap_year);
      logic [4:0] d;
      case (m) inside
         MONTH_FEB: d = leap_year ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### sv/clock_calendar_tick.sv
// Channel   Direction  Payload              Handshake
// req_      in         ccal_pkg::req_type   req_valid, req_stall
// rsp_      out        ccal_pkg::rsp_type   rsp_valid, rsp_stall
//
// One beat can be taken in every cycle while req_stall is low. The result
// of a beat appears on the next cycle in the result register, or in the
// skid register while rsp_stall holds the result register. The two-entry
// output buffer raises req_stall only while the skid register is full.
// Synchronous reset sets 00:00:00 on January 1 of year 0 and empties both
// output registers.
`timescale 1ns / 1ps
`default_nettype none

module clock_calendar_tick #(
   parameter int YEAR_BITS = ccal_pkg::YEAR_BITS_DFLT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ccal_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ccal_pkg::rsp_type      rsp_data
);

   logic [4:0]           hour_ff,   hour_in;
   logic [5:0]           minute_ff, minute_in;
   logic [5:0]           second_ff, second_in;
   logic [4:0]           day_ff,    day_in;
   logic [3:0]           month_ff,  month_in;
   logic [YEAR_BITS-1:0] year_ff,   year_in;

   ccal_pkg::rsp_type    out_ff, out_in;
   ccal_pkg::rsp_type    skid_ff, skid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;

   logic                 accept;
   logic                 out_free;
   logic                 is_tick;
   logic                 sec_wrap, min_wrap, hour_wrap, midnight;
   logic [4:0]           cur_month_len;
   logic [YEAR_BITS-1:0] load_year_masked;
   logic [4:0]           load_month_len;
   logic                 load_ok;
   ccal_pkg::rsp_type    result;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign is_tick   = (req_data.command == ccal_pkg::CMD_TICK);
   assign sec_wrap  = (second_ff == ccal_pkg::LAST_SECOND);
   assign min_wrap  = (minute_ff == ccal_pkg::LAST_MINUTE);
   assign hour_wrap = (hour_ff == ccal_pkg::LAST_HOUR);
   assign midnight  = is_tick && sec_wrap && min_wrap && hour_wrap;

   assign cur_month_len = ccal_pkg::days_in(month_ff,
      ccal_pkg::is_leap(ccal_pkg::YEAR_MAX_BITS'(year_ff)));

   assign load_year_masked = YEAR_BITS'(req_data.load_year);
   assign load_month_len   = ccal_pkg::days_in(req_data.load_month,
      ccal_pkg::is_leap(ccal_pkg::YEAR_MAX_BITS'(load_year_masked)));

   assign load_ok = (req_data.load_hour <= ccal_pkg::LAST_HOUR)
                 && (req_data.load_minute <= ccal_pkg::LAST_MINUTE)
                 && (req_data.load_second <= ccal_pkg::LAST_SECOND)
                 && (req_data.load_month >= ccal_pkg::MONTH_JAN)
                 && (req_data.load_month <= ccal_pkg::MONTH_DEC)
                 && (req_data.load_day >= ccal_pkg::FIRST_DAY)
                 && (req_data.load_day <= load_month_len);

   always_comb begin
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      if (is_tick) begin
         second_in = sec_wrap ? 6'd0 : second_ff + 6'd1;
         if (sec_wrap) begin
            minute_in = min_wrap ? 6'd0 : minute_ff + 6'd1;
            if (min_wrap) begin
               hour_in = hour_wrap ? 5'd0 : hour_ff + 5'd1;
               if (hour_wrap) begin
                  if (day_ff < cur_month_len) begin
                     day_in = day_ff + 5'd1;
                  end else if (month_ff == ccal_pkg::MONTH_DEC) begin
                     day_in   = ccal_pkg::FIRST_DAY;
                     month_in = ccal_pkg::MONTH_JAN;
                     year_in  = year_ff + YEAR_BITS'(1);
                  end else begin
                     day_in   = ccal_pkg::FIRST_DAY;
                     month_in = month_ff + 4'd1;
                  end
               end
            end
         end
      end else if (load_ok) begin
         hour_in   = req_data.load_hour;
         minute_in = req_data.load_minute;
         second_in = req_data.load_second;
         day_in    = req_data.load_day;
         month_in  = req_data.load_month;
         year_in   = load_year_masked;
      end
   end

   always_comb begin
      result.hour              = hour_in;
      result.minute            = minute_in;
      result.second            = second_in;
      result.day               = day_in;
      result.month             = month_in;
      result.year              = ccal_pkg::YEAR_FIELD_BITS'(year_in);
      result.midnight_rollover = midnight;
      result.load_rejected     = !is_tick && !load_ok;
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff       <= 5'd0;
         minute_ff     <= 6'd0;
         second_ff     <= 6'd0;
         day_ff        <= ccal_pkg::FIRST_DAY;
         month_ff      <= ccal_pkg::MONTH_JAN;
         year_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            hour_ff   <= hour_in;
            minute_ff <= minute_in;
            second_ff <= second_in;
            day_ff    <= day_in;
            month_ff  <= month_in;
            year_ff   <= year_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid register holds a beat while the result register is empty.");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      (hour_ff <= ccal_pkg::LAST_HOUR) && (minute_ff <= ccal_pkg::LAST_MINUTE)
      && (second_ff <= ccal_pkg::LAST_SECOND) && (month_ff >= ccal_pkg::MONTH_JAN)
      && (month_ff <= ccal_pkg::MONTH_DEC) && (day_ff >= ccal_pkg::FIRST_DAY))
      else $error("Clock state left its calendar range.");

   a_reject_holds_state: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_tick && !load_ok) |=>
         ($stable(hour_ff) && $stable(minute_ff) && $stable(second_ff)
          && $stable(day_ff) && $stable(month_ff) && $stable(year_ff)))
      else $error("A rejected load changed the clock state.");

   a_midnight_wraps_date: assert property (@(posedge clock) disable iff (reset)
      (accept && midnight) |=>
         (hour_ff == 5'd0) && (minute_ff == 6'd0) && (second_ff == 6'd0)
         && (day_ff == ccal_pkg::FIRST_DAY || day_ff == $past(day_ff) + 5'd1))
      else $error("Midnight tick did not wrap the time and advance the date.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.midnight_rollover && out_ff.load_rejected))
      else $error("Result shows both midnight and reject flags.");

endmodule

`default_nettype wire
